// ===== hw/rtl/jeo_pkg.sv =====
// Package for the Josephus elimination order core.
// Holds the transaction payload types, the control state encoding and fixed widths.
// No dependencies.
package jeo_pkg;

	localparam int CNT_W     = 7;
	localparam int STEP_W    = 16;
	localparam int DIV_STEPS = 16;
	localparam int DIV_CNT_W = 4;

	// Input transaction: one whole problem.
	typedef struct packed {
		logic [CNT_W-1:0]  person_count;
		logic [CNT_W-1:0]  start_position;
		logic [STEP_W-1:0] step_length;
	} item_t;

	// Output transaction: one removed person, or the survivor.
	typedef struct packed {
		logic [CNT_W-1:0] person_id;
		logic             is_last;
	} result_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FILL,
		ST_DIV_START,
		ST_DIV_STEP,
		ST_SCAN,
		ST_EMIT
	} state_t;

endpackage

// ===== hw/rtl/jeo_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// No dependencies.
module jeo_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Read port, data registered on the clock after rd_en
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ===== hw/rtl/josephus_elimination_order_core.sv =====
// Josephus elimination order core: top level.
// Depends on jeo_pkg and jeo_ram.
//
// Each input transaction is one complete problem: n people (the count, capped at MAX_PEOPLE),
// a start position and a step length. The block emits one result transaction per removed
// person in removal order, then the survivor with is_last set; a count of zero gives no
// result. The live map sits in a 1-bit RAM with registered read. An item first marks people
// 1..n live (the start offset is divided out in parallel), then per result it takes the step
// remainder on the shared serial divider, scans the live map one entry per cycle over fewer
// than n entries, and emits; the output can be held off by result_ready. A new item is taken
// only once the previous survivor is in the output register.
module josephus_elimination_order_core #(
	parameter int MAX_PEOPLE = 64
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_ready,
	input  jeo_pkg::item_t   item,
	output logic             result_valid,
	input  logic             result_ready,
	output jeo_pkg::result_t result
);

	localparam int IDX_W   = $clog2(MAX_PEOPLE);
	localparam int CMP_W   = (IDX_W > jeo_pkg::CNT_W) ? IDX_W : jeo_pkg::CNT_W;
	localparam int CNT_CAP = (MAX_PEOPLE < 127) ? MAX_PEOPLE : 127;
	localparam int CW      = jeo_pkg::CNT_W;
	localparam int SW      = jeo_pkg::STEP_W;

	jeo_pkg::state_t state_q, state_d;

	logic [CW-1:0]    n_q, rem_q, need_q, hits_q;
	logic [SW-1:0]    step_m1_q;
	logic [IDX_W-1:0] cur_q, scan_q, target_q, rd_addr_s1;
	logic             cur_live_q;

	logic [SW-1:0]                dvd_q;
	logic [CW-1:0]                dacc_q;
	logic [jeo_pkg::DIV_CNT_W-1:0] dcnt_q;
	logic                         div_busy_q;

	logic             rd_valid_s1;
	logic             out_valid_q;
	jeo_pkg::result_t out_q;

	logic             accept_go, div_load, emit_load, scan_found, div_done;
	logic             ram_we, ram_wdata, ram_re, ram_rdata;
	logic [IDX_W-1:0] ram_waddr;
	logic [CW-1:0]    n_sat, start_m1, divisor, dacc_next, need_new, hits_inc;
	logic [CW:0]      trial;
	logic [IDX_W-1:0] scan_next, cur_next;

	// Wrap an index at the current count
	function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] p,
	                                              input logic [CW-1:0] n);
		logic [CW-1:0] last;
		last = n - 7'd1;
		if (CMP_W'(p) == CMP_W'(last)) begin
			return '0;
		end
		return p + 1'b1;
	endfunction

	// Saturate count, clamp start
	assign n_sat    = (item.person_count > CW'(CNT_CAP)) ? CW'(CNT_CAP) : item.person_count;
	assign start_m1 = (item.start_position == '0) ? '0 : item.start_position - 7'd1;

	// Serial restoring divider, one quotient bit per cycle; only the remainder is kept
	assign divisor   = (state_q == jeo_pkg::ST_DIV_STEP) ? rem_q : n_q;
	assign trial     = {dacc_q, dvd_q[SW-1]};
	assign dacc_next = (trial >= {1'b0, divisor}) ? CW'(trial - {1'b0, divisor}) : trial[CW-1:0];
	assign div_done  = div_busy_q && (dcnt_q == '0);
	assign need_new  = cur_live_q ? dacc_next : dacc_next + 7'd1;

	assign hits_inc  = hits_q + 7'd1;
	assign scan_next = wrap_inc(scan_q, n_q);
	assign cur_next  = wrap_inc(cur_q, n_q);
	assign accept_go = item_valid && item_ready && (item.person_count != '0);

	// Next state and control strobes
	always_comb begin
		state_d    = state_q;
		item_ready = 1'b0;
		div_load   = 1'b0;
		emit_load  = 1'b0;
		scan_found = 1'b0;
		ram_we     = 1'b0;
		ram_waddr  = scan_q;
		ram_wdata  = 1'b1;
		ram_re     = 1'b0;
		case (state_q)
			jeo_pkg::ST_IDLE: begin
				item_ready = 1'b1;
				if (item_valid && item.person_count != '0) begin
					state_d = jeo_pkg::ST_FILL;
				end
			end
			jeo_pkg::ST_FILL: begin
				ram_we = 1'b1;
				if (scan_next == '0) begin
					state_d = jeo_pkg::ST_DIV_START;
				end
			end
			jeo_pkg::ST_DIV_START: begin
				if (!div_busy_q) begin
					div_load = 1'b1;
					state_d  = jeo_pkg::ST_DIV_STEP;
				end
			end
			jeo_pkg::ST_DIV_STEP: begin
				if (div_done) begin
					state_d = (need_new == '0) ? jeo_pkg::ST_EMIT : jeo_pkg::ST_SCAN;
				end
			end
			jeo_pkg::ST_SCAN: begin
				if (rd_valid_s1 && ram_rdata && (hits_inc == need_q)) begin
					scan_found = 1'b1;
					state_d    = jeo_pkg::ST_EMIT;
				end else begin
					ram_re = 1'b1;
				end
			end
			jeo_pkg::ST_EMIT: begin
				if (!out_valid_q || result_ready) begin
					emit_load = 1'b1;
					if (rem_q == 7'd1) begin
						state_d = jeo_pkg::ST_IDLE;
					end else begin
						ram_we    = 1'b1;
						ram_waddr = target_q;
						ram_wdata = 1'b0;
						div_load  = 1'b1;
						state_d   = jeo_pkg::ST_DIV_STEP;
					end
				end
			end
			default: begin
				state_d = jeo_pkg::ST_IDLE;
			end
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= jeo_pkg::ST_IDLE;
			div_busy_q  <= 1'b0;
			rd_valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			rd_valid_s1 <= ram_re;
			if (accept_go || div_load) begin
				div_busy_q <= 1'b1;
			end else if (div_done) begin
				div_busy_q <= 1'b0;
			end
			if (emit_load) begin
				out_valid_q <= 1'b1;
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		// Take a new problem and start the start-offset division
		if (accept_go) begin
			n_q        <= n_sat;
			rem_q      <= n_sat;
			step_m1_q  <= (item.step_length == '0) ? '0 : item.step_length - 16'd1;
			cur_live_q <= 1'b1;
			scan_q     <= '0;
			dvd_q      <= SW'(start_m1);
			dacc_q     <= '0;
			dcnt_q     <= jeo_pkg::DIV_CNT_W'(jeo_pkg::DIV_STEPS - 1);
		end else if (div_load) begin
			dvd_q  <= step_m1_q;
			dacc_q <= '0;
			dcnt_q <= jeo_pkg::DIV_CNT_W'(jeo_pkg::DIV_STEPS - 1);
		end else if (div_busy_q) begin
			dvd_q  <= {dvd_q[SW-2:0], 1'b0};
			dacc_q <= dacc_next;
			dcnt_q <= dcnt_q - 1'b1;
		end

		// Advance fill address
		if (state_q == jeo_pkg::ST_FILL) begin
			scan_q <= scan_next;
		end

		// Latch start offset when the first division ends
		if (div_done && state_q != jeo_pkg::ST_DIV_STEP) begin
			cur_q <= IDX_W'(dacc_next);
		end

		// Step remainder ready: set up the scan
		if (div_done && state_q == jeo_pkg::ST_DIV_STEP) begin
			need_q   <= need_new;
			hits_q   <= '0;
			target_q <= cur_q;
			scan_q   <= cur_next;
		end

		// Walk the live map
		if (ram_re) begin
			scan_q     <= scan_next;
			rd_addr_s1 <= scan_q;
		end
		if (state_q == jeo_pkg::ST_SCAN && rd_valid_s1 && ram_rdata) begin
			hits_q <= hits_inc;
		end
		if (scan_found) begin
			target_q <= rd_addr_s1;
		end

		// Emit and drop the target
		if (emit_load) begin
			out_q.person_id <= CW'(target_q) + 7'd1;
			out_q.is_last   <= (rem_q == 7'd1);
			rem_q           <= rem_q - 7'd1;
			cur_q           <= target_q;
			cur_live_q      <= 1'b0;
		end
	end

	jeo_ram #(
		.WIDTH(1),
		.DEPTH(MAX_PEOPLE)
	) u_alive_ram (
		.clk    (clk),
		.wr_en  (ram_we),
		.wr_addr(ram_waddr),
		.wr_data(ram_wdata),
		.rd_en  (ram_re),
		.rd_addr(scan_q),
		.rd_data(ram_rdata)
	);

	assign result_valid = out_valid_q;
	assign result       = out_q;

	// Live count never reaches zero while a problem is in flight
	a_rem_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != jeo_pkg::ST_IDLE) |-> (rem_q != '0))
		else $error("remaining count is zero during a run");

	// Scan stays inside the circle
	a_scan_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		ram_re |-> (CMP_W'(scan_q) < CMP_W'(n_q)))
		else $error("scan address beyond person count");

	// Map writes stay inside the circle
	a_write_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (CMP_W'(ram_waddr) < CMP_W'(n_q)))
		else $error("live map write beyond person count");

	// Hit counter never passes the target count
	a_hits_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == jeo_pkg::ST_SCAN) |-> (hits_q < need_q))
		else $error("scan passed its target");

	// Emitted ids are real people
	a_id_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (result.person_id != '0 && result.person_id <= CW'(CNT_CAP)))
		else $error("person id out of range");

endmodule

// ===== dv/josephus_elimination_order_core_tb.sv =====
// Testbench for josephus_elimination_order_core: directed and random problems, checked in order.
// Depends on jeo_pkg and the core RTL; the expected removal order is predicted here.
// Sender bursts and receiver stall patterns are randomized from the simulator seed.
module josephus_elimination_order_core_tb;

	localparam int MAX_PEOPLE   = 64;
	localparam int RANDOM_ITEMS = 122;
	localparam int SETTLE_CYCLES = 6000;

	typedef enum int {
		RX_OPEN,
		RX_MOSTLY,
		RX_SPARSE,
		RX_PERIODIC
	} rx_mode_e;

	// Predict the removal order of each accepted problem and check results against it.
	class elimination_scoreboard;
		bit               live_seat[MAX_PEOPLE];
		jeo_pkg::result_t removal_order_q[$];
		int               errors;
		int               problems;
		int               empty_circles;
		int               capped_circles;
		int               removals_checked;
		int               survivors_checked;

		function new();
			errors = 0;
			problems = 0;
			empty_circles = 0;
			capped_circles = 0;
			removals_checked = 0;
			survivors_checked = 0;
		endfunction

		// Walk round the circle to the next live seat; stay put if no other seat is live.
		function int next_live_seat(int p);
			int q;
			q = p;
			for (int k = 0; k < MAX_PEOPLE; k++) begin
				q = (q + 1) % MAX_PEOPLE;
				if (live_seat[q])
					return q;
			end
			return p;
		endfunction

		function void note_problem(jeo_pkg::item_t p);
			int               n;
			int               seat;
			int               left;
			int               hops;
			jeo_pkg::result_t r;
			problems++;
			n = int'(p.person_count);
			if (n == 0) begin
				empty_circles++;
				return;
			end
			if (n > MAX_PEOPLE) begin
				n = MAX_PEOPLE;
				capped_circles++;
			end
			foreach (live_seat[j])
				live_seat[j] = (j < n);
			seat = (p.start_position == 0) ? 0 : (int'(p.start_position) - 1) % n;
			left = n;
			// Drop one person per lap segment until a single survivor remains.
			while (left > 1) begin
				hops = (p.step_length == 0) ? 0 : (int'(p.step_length) - 1) % left;
				for (int k = 0; k < hops; k++)
					seat = next_live_seat(seat);
				live_seat[seat] = 1'b0;
				r.person_id = jeo_pkg::CNT_W'(seat + 1);
				r.is_last = 1'b0;
				removal_order_q.push_back(r);
				left--;
				seat = next_live_seat(seat);
			end
			r.person_id = jeo_pkg::CNT_W'(seat + 1);
			r.is_last = 1'b1;
			removal_order_q.push_back(r);
		endfunction

		function void check_removal(jeo_pkg::result_t got);
			jeo_pkg::result_t want;
			if (removal_order_q.size() == 0) begin
				$display("%0t: unexpected result person_id=%0d is_last=%0b",
					$time, got.person_id, got.is_last);
				errors++;
				return;
			end
			want = removal_order_q.pop_front();
			if (got.person_id !== want.person_id) begin
				$display("%0t: person_id mismatch, expected %0d, actual %0d",
					$time, want.person_id, got.person_id);
				errors++;
			end
			if (got.is_last !== want.is_last) begin
				$display("%0t: is_last mismatch, expected %0b, actual %0b",
					$time, want.is_last, got.is_last);
				errors++;
			end
			if (want.is_last)
				survivors_checked++;
			else
				removals_checked++;
		endfunction

		function int outstanding();
			return removal_order_q.size();
		endfunction
	endclass

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             item_valid = 1'b0;
	logic             item_ready;
	jeo_pkg::item_t   item = '0;
	logic             result_valid;
	logic             result_ready = 1'b0;
	jeo_pkg::result_t result;

	elimination_scoreboard sb = new();

	rx_mode_e rx_mode = RX_OPEN;
	int       rx_mode_left = 0;
	int       rx_tick = 0;

	josephus_elimination_order_core #(
		.MAX_PEOPLE(MAX_PEOPLE)
	) i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item_ready  (item_ready),
		.item        (item),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result      (result)
	);

	// Free-running clock, period 10.
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Check each result transaction and pick the next ready value from the current stall pattern.
	always @(posedge clk) begin
		if (arst_n && result_valid && result_ready)
			sb.check_removal(result);
		rx_tick <= rx_tick + 1;
		if (rx_mode_left == 0) begin
			rx_mode <= rx_mode_e'($urandom_range(0, 3));
			rx_mode_left <= $urandom_range(16, 200);
		end else begin
			rx_mode_left <= rx_mode_left - 1;
		end
		case (rx_mode)
			RX_OPEN:     result_ready <= 1'b1;
			RX_MOSTLY:   result_ready <= ($urandom_range(0, 3) != 0);
			RX_SPARSE:   result_ready <= ($urandom_range(0, 3) == 0);
			RX_PERIODIC: result_ready <= ((rx_tick % 7) >= 3);
			default:     result_ready <= 1'b1;
		endcase
	end

	// Present one problem and hold it until the core takes it.
	task automatic offer_problem(input jeo_pkg::item_t p);
		item_valid <= 1'b1;
		item <= p;
		do
			@(posedge clk);
		while (!item_ready);
		sb.note_problem(p);
	endtask

	// Drop valid for a gap; a zero gap keeps the sender streaming.
	task automatic sender_gap(input int cycles);
		if (cycles > 0) begin
			item_valid <= 1'b0;
			repeat (cycles)
				@(posedge clk);
		end
	endtask

	// Hold off the sender until every predicted result has come back.
	task automatic drain_results();
		item_valid <= 1'b0;
		@(posedge clk);
		while (sb.outstanding() > 0)
			@(posedge clk);
	endtask

	function automatic jeo_pkg::item_t make_problem(input int n, input int s, input int k);
		jeo_pkg::item_t p;
		p.person_count = jeo_pkg::CNT_W'(n);
		p.start_position = jeo_pkg::CNT_W'(s);
		p.step_length = jeo_pkg::STEP_W'(k);
		return p;
	endfunction

	// Mostly small circles with sane starts, a few large or out-of-range ones.
	function automatic jeo_pkg::item_t random_problem();
		jeo_pkg::item_t p;
		int             sel;
		sel = $urandom_range(0, 99);
		if (sel < 75)
			p.person_count = jeo_pkg::CNT_W'($urandom_range(1, 16));
		else if (sel < 88)
			p.person_count = jeo_pkg::CNT_W'($urandom_range(17, 64));
		else if (sel < 95)
			p.person_count = jeo_pkg::CNT_W'($urandom_range(65, 127));
		else
			p.person_count = '0;
		if ($urandom_range(0, 2) != 0 && p.person_count != 0)
			p.start_position = jeo_pkg::CNT_W'($urandom_range(1, p.person_count > 64 ?
				64 : p.person_count));
		else
			p.start_position = jeo_pkg::CNT_W'($urandom_range(0, 127));
		if ($urandom_range(0, 1) != 0)
			p.step_length = jeo_pkg::STEP_W'($urandom_range(1, 20));
		else
			p.step_length = jeo_pkg::STEP_W'($urandom_range(0, 65535));
		return p;
	endfunction

	// Stop a hung run.
	initial begin
		#50_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		int burst;
		int sent;
		int drained_at;
		repeat (9)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: single person, empty circle, full and saturated circles,
		// zero and wrapping starts, zero and long steps.
		offer_problem(make_problem(1, 1, 1));
		offer_problem(make_problem(0, 1, 1));
		offer_problem(make_problem(64, 1, 1));
		offer_problem(make_problem(64, 64, 65535));
		offer_problem(make_problem(127, 127, 3));
		offer_problem(make_problem(65, 0, 0));
		offer_problem(make_problem(7, 0, 3));
		offer_problem(make_problem(7, 100, 3));
		offer_problem(make_problem(7, 3, 0));
		offer_problem(make_problem(5, 2, 65535));
		offer_problem(make_problem(2, 2, 2));
		offer_problem(make_problem(41, 1, 3));
		offer_problem(make_problem(10, 10, 10));
		offer_problem(make_problem(3, 127, 65534));
		offer_problem(make_problem(0, 127, 65535));
		offer_problem(make_problem(1, 127, 0));
		offer_problem(make_problem(64, 33, 32768));
		offer_problem(make_problem(2, 0, 65535));
		drain_results();

		// Random problems in bursts, with one full drain midway.
		sent = 0;
		drained_at = $urandom_range(50, 90);
		while (sent < RANDOM_ITEMS) begin
			burst = $urandom_range(1, 8);
			for (int b = 0; b < burst && sent < RANDOM_ITEMS; b++) begin
				offer_problem(random_problem());
				sent++;
			end
			if (drained_at >= 0 && sent >= drained_at) begin
				drain_results();
				drained_at = -1;
			end else if ($urandom_range(0, 3) == 0) begin
				sender_gap(0);
			end else begin
				sender_gap($urandom_range(1, 12));
			end
		end

		// Let the last results out, then watch for strays.
		item_valid <= 1'b0;
		while (sb.outstanding() > 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES)
			@(posedge clk);

		$display("Ran %0d problems (%0d empty circles, %0d capped at %0d people).",
			sb.problems, sb.empty_circles, sb.capped_circles, MAX_PEOPLE);
		$display("Checked %0d removals and %0d survivors.",
			sb.removals_checked, sb.survivors_checked);
		if (sb.errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
